### sv/r30dc_pkg.sv
`default_nettype none

package r30dc_pkg;

    // number of edge cells per half, sets the depth of the chain
    localparam int EDGE_CELLS = 16;
    // width of an edge field
    localparam int EDGE_W = 33;
    // width of the working row
    localparam int ROW_W = 64;
    // bits to name a generation inside one half of the chain
    localparam int IDX_W = (EDGE_CELLS > 1) ? $clog2(EDGE_CELLS) : 1;
    // bits to name a cell position, wide enough to hold ROW_W itself
    localparam int CELL_IDX_W = $clog2(ROW_W) + 1;
    localparam int EDGE_SEL_W = $clog2(EDGE_W);
    localparam int ROW_SEL_W = $clog2(ROW_W);

    typedef logic [EDGE_W-1:0] t_edge;
    typedef logic [ROW_W-1:0] t_row;
    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CELL_IDX_W-1:0] t_cidx;

    // payload carried through the growing half
    typedef struct packed {
        t_row  row;
        t_edge lft;
        t_edge rgt;
    } t_grow;

    // payload carried through the shrinking half
    typedef struct packed {
        t_row  row;
        t_edge nl;
        t_edge nr;
    } t_shrink;

    // one rule 30 generation, zero beyond both ends
    function automatic t_row generation(t_row b);
        return (b >> 1) ^ (b | (b << 1));
    endfunction

    // read an edge cell, zero beyond the field
    function automatic logic get_edge(t_edge e, t_cidx k);
        logic bit_v;
        bit_v = 1'b0;
        if (k < CELL_IDX_W'(EDGE_W)) begin
            bit_v = e[k[EDGE_SEL_W-1:0]];
        end
        return bit_v;
    endfunction

    // write an edge cell, dropped beyond the field
    function automatic t_edge put_edge(t_edge e, t_cidx k, logic b);
        t_edge v;
        v = e;
        if (k < CELL_IDX_W'(EDGE_W)) begin
            v[k[EDGE_SEL_W-1:0]] = b;
        end
        return v;
    endfunction

    // read a row cell, zero beyond the row
    function automatic logic get_row(t_row r, t_cidx k);
        logic bit_v;
        bit_v = 1'b0;
        if (k < CELL_IDX_W'(ROW_W)) begin
            bit_v = r[k[ROW_SEL_W-1:0]];
        end
        return bit_v;
    endfunction

    // write a row cell, dropped beyond the row
    function automatic t_row put_row(t_row r, t_cidx k, logic b);
        t_row v;
        v = r;
        if (k < CELL_IDX_W'(ROW_W)) begin
            v[k[ROW_SEL_W-1:0]] = b;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

### sv/r30dc_grow_cell.sv
`default_nettype none

module r30dc_grow_cell (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire r30dc_pkg::t_idx  i_stage,
    input  wire logic             i_valid,
    input  wire r30dc_pkg::t_grow i_data,
    output logic                  o_stall,
    input  wire logic             i_stall,
    output logic                  o_valid,
    output r30dc_pkg::t_grow      o_data
);
    import r30dc_pkg::*;

    logic  r_valid;
    t_grow r_data;
    t_grow n_data;
    t_cidx l_v;
    t_cidx k_lo;
    t_cidx k_hi;

    // edge cell positions taken in this generation
    assign l_v  = CELL_IDX_W'(i_stage);
    assign k_lo = CELL_IDX_W'(2) + (l_v << 1);
    assign k_hi = CELL_IDX_W'(3) + (l_v << 1);

    // one growing generation and injection of the boundary cells
    always_comb begin
        t_row row_v;
        row_v = generation(i_data.row);
        if (l_v + CELL_IDX_W'(1) < CELL_IDX_W'(EDGE_CELLS)) begin
            row_v = row_v << 1;
            row_v = put_row(row_v, CELL_IDX_W'(1), get_edge(i_data.lft, k_lo));
            row_v = put_row(row_v, k_lo + CELL_IDX_W'(1), get_edge(i_data.rgt, k_lo));
            row_v = put_row(row_v, CELL_IDX_W'(0), get_edge(i_data.lft, k_hi));
            row_v = put_row(row_v, k_hi + CELL_IDX_W'(1), get_edge(i_data.rgt, k_hi));
        end else begin
            row_v = put_row(row_v, CELL_IDX_W'(0), get_edge(i_data.lft, k_lo));
            row_v = put_row(row_v, k_lo, get_edge(i_data.rgt, k_lo));
        end
        n_data.row = row_v;
        n_data.lft = i_data.lft;
        n_data.rgt = i_data.rgt;
    end

    // hold while a request sits here and the next cell is stalled
    assign o_stall = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

### sv/r30dc_shrink_cell.sv
`default_nettype none

module r30dc_shrink_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire r30dc_pkg::t_idx    i_stage,
    input  wire logic               i_valid,
    input  wire r30dc_pkg::t_shrink i_data,
    output logic                    o_stall,
    input  wire logic               i_stall,
    output logic                    o_valid,
    output r30dc_pkg::t_shrink      o_data
);
    import r30dc_pkg::*;

    logic    r_valid;
    t_shrink r_data;
    t_shrink n_data;
    t_cidx   i_v;
    t_cidx   k_left;
    t_cidx   k_right;
    t_cidx   k_out;

    // row cells watched and output cells written in this generation
    assign i_v     = CELL_IDX_W'(i_stage);
    assign k_left  = i_v + CELL_IDX_W'(1);
    assign k_right = CELL_IDX_W'(2 * EDGE_CELLS) - i_v - CELL_IDX_W'(1);
    assign k_out   = CELL_IDX_W'(1) + (i_v << 1);

    // sample the row, step one generation, sample again
    always_comb begin
        t_row  row_v;
        t_edge nl_v;
        t_edge nr_v;
        nl_v  = put_edge(i_data.nl, k_out, get_row(i_data.row, k_left));
        nr_v  = put_edge(i_data.nr, k_out, get_row(i_data.row, k_right));
        row_v = generation(i_data.row);
        nl_v  = put_edge(nl_v, k_out + CELL_IDX_W'(1), get_row(row_v, k_left));
        nr_v  = put_edge(nr_v, k_out + CELL_IDX_W'(1), get_row(row_v, k_right));
        n_data.row = row_v;
        n_data.nl  = nl_v;
        n_data.nr  = nr_v;
    end

    // hold while a request sits here and the next cell is stalled
    assign o_stall = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

### sv/rule30_diamond_chunk_step_core.sv
// channel   direction  handshake          payload
// input     in         i_valid / o_stall  i_left_edge, i_right_edge
// output    out        o_valid / i_stall  o_new_left_edge, o_new_right_edge
//
// a request passes a chain of 2*EDGE_CELLS cells, one rule 30 generation per cell;
// one request accepted per cycle while o_stall is low.
// the last cell's registers drive the output ports directly.
// reset (synchronous, active low) clears only the valid bits of the cells.
// a stall holds the occupied cells at the tail; empty cells upstream keep filling.
`default_nettype none

module rule30_diamond_chunk_step_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire r30dc_pkg::t_edge i_left_edge,
    input  wire r30dc_pkg::t_edge i_right_edge,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output r30dc_pkg::t_edge      o_new_left_edge,
    output r30dc_pkg::t_edge      o_new_right_edge
);
    import r30dc_pkg::*;

    logic    grow_valid [EDGE_CELLS+1];
    logic    grow_stall [EDGE_CELLS+1];
    t_grow   grow_data  [EDGE_CELLS+1];
    logic    shr_valid  [EDGE_CELLS+1];
    logic    shr_stall  [EDGE_CELLS+1];
    t_shrink shr_data   [EDGE_CELLS+1];

    // seed row from the corner cells of both input edges
    always_comb begin
        grow_data[0].row    = '0;
        grow_data[0].row[0] = i_left_edge[1];
        grow_data[0].row[1] = i_left_edge[0];
        grow_data[0].row[2] = i_right_edge[1];
        grow_data[0].lft    = i_left_edge;
        grow_data[0].rgt    = i_right_edge;
    end
    assign grow_valid[0] = i_valid;
    assign o_stall       = grow_stall[0];

    // growing half of the chain
    for (genvar g = 0; g < EDGE_CELLS; g++) begin : g_grow
        r30dc_grow_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (IDX_W'(g)),
            .i_valid (grow_valid[g]),
            .i_data  (grow_data[g]),
            .o_stall (grow_stall[g]),
            .i_stall (grow_stall[g+1]),
            .o_valid (grow_valid[g+1]),
            .o_data  (grow_data[g+1])
        );
    end

    // output corner cells copy the far corner of each input edge
    always_comb begin
        shr_data[0].row = grow_data[EDGE_CELLS].row;
        shr_data[0].nl  = put_edge('0, CELL_IDX_W'(0),
                                   get_edge(grow_data[EDGE_CELLS].lft,
                                            CELL_IDX_W'(2 * EDGE_CELLS)));
        shr_data[0].nr  = put_edge('0, CELL_IDX_W'(0),
                                   get_edge(grow_data[EDGE_CELLS].rgt,
                                            CELL_IDX_W'(2 * EDGE_CELLS)));
    end
    assign shr_valid[0]           = grow_valid[EDGE_CELLS];
    assign grow_stall[EDGE_CELLS] = shr_stall[0];

    // shrinking half of the chain
    for (genvar g = 0; g < EDGE_CELLS; g++) begin : g_shrink
        r30dc_shrink_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (IDX_W'(g)),
            .i_valid (shr_valid[g]),
            .i_data  (shr_data[g]),
            .o_stall (shr_stall[g]),
            .i_stall (shr_stall[g+1]),
            .o_valid (shr_valid[g+1]),
            .o_data  (shr_data[g+1])
        );
    end

    // result straight from the last cell
    assign shr_stall[EDGE_CELLS] = i_stall;
    assign o_valid          = shr_valid[EDGE_CELLS];
    assign o_new_left_edge  = shr_data[EDGE_CELLS].nl;
    assign o_new_right_edge = shr_data[EDGE_CELLS].nr;

endmodule

`default_nettype wire
